// File: src/spq_pkg.sv
package spq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned KEY_W     = 16;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned OCC_W     = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_POP    = 2'd2,
    FUNC_FIND   = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_TAIL,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    start;
    logic    rd_req;
    logic    shift_wr;
    logic    idx_inc;
    logic    tail_wr;
    logic    pop;
    logic    capture;
    logic    clr_res;
    logic    load_out;
    status_e status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic idx_end;
    logic key_gt;
    logic id_match;
    logic out_free;
  } stat_t;

endpackage

// File: src/spq_req_if.sv
interface spq_req_if;
  logic                           valid;
  logic                           ready;
  logic [spq_pkg::FUNC_W-1:0]     func;
  logic [spq_pkg::KEY_W-1:0]      entry_key;
  logic [spq_pkg::ID_W-1:0]       entry_id;

  modport source (output valid, output func, output entry_key, output entry_id,
                  input ready);
  modport sink (input valid, input func, input entry_key, input entry_id,
                output ready);
endinterface

// File: src/spq_rsp_if.sv
interface spq_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [spq_pkg::STATUS_W-1:0]   status;
  logic [spq_pkg::KEY_W-1:0]      out_key;
  logic [spq_pkg::ID_W-1:0]       out_id;
  logic [spq_pkg::OCC_W-1:0]      occupancy;

  modport source (output valid, output status, output out_key, output out_id,
                  output occupancy, input ready);
  modport sink (input valid, input status, input out_key, input out_id,
                input occupancy, output ready);
endinterface

// File: src/spq_ctrl.sv
module spq_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  input  logic [spq_pkg::FUNC_W-1:0] req_func_i,
  output logic                       req_ready_o,
  input  spq_pkg::stat_t             stat_i,
  output spq_pkg::cmd_t              cmd_o
);

  spq_pkg::state_e  state_q, state_d;
  spq_pkg::func_e   func_q, func_d;
  spq_pkg::status_e status_q, status_d;
  logic             shifting_q, shifting_d;
  spq_pkg::func_e   func_in;
  logic             accept;

  assign func_in = spq_pkg::func_e'(req_func_i);
  assign accept  = (state_q == spq_pkg::S_IDLE) && req_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= spq_pkg::S_IDLE;
      func_q     <= spq_pkg::FUNC_APPEND;
      status_q   <= spq_pkg::ST_OK;
      shifting_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      func_q     <= func_d;
      status_q   <= status_d;
      shifting_q <= shifting_d;
    end
  end

  // next state
  always_comb begin
    state_d    = state_q;
    func_d     = func_q;
    status_d   = status_q;
    shifting_d = shifting_q;
    unique case (state_q)
      spq_pkg::S_IDLE: begin
        if (req_valid_i) begin
          func_d     = func_in;
          shifting_d = 1'b0;
          status_d   = spq_pkg::ST_OK;
          unique case (func_in)
            spq_pkg::FUNC_APPEND: begin
              if (stat_i.full) begin
                status_d = spq_pkg::ST_FULL;
                state_d  = spq_pkg::S_DONE;
              end else begin
                state_d  = spq_pkg::S_TAIL;
              end
            end
            spq_pkg::FUNC_INSERT: begin
              if (stat_i.full) begin
                status_d = spq_pkg::ST_FULL;
                state_d  = spq_pkg::S_DONE;
              end else begin
                state_d  = spq_pkg::S_READ;
              end
            end
            spq_pkg::FUNC_POP: begin
              if (stat_i.empty) begin
                status_d = spq_pkg::ST_EMPTY;
                state_d  = spq_pkg::S_DONE;
              end else begin
                state_d  = spq_pkg::S_READ;
              end
            end
            default: state_d = spq_pkg::S_READ;
          endcase
        end
      end
      spq_pkg::S_READ: begin
        if (stat_i.idx_end) begin
          if (func_q == spq_pkg::FUNC_FIND) begin
            status_d = spq_pkg::ST_NOTFOUND;
            state_d  = spq_pkg::S_DONE;
          end else begin
            state_d  = spq_pkg::S_TAIL;
          end
        end else begin
          state_d = spq_pkg::S_CHECK;
        end
      end
      spq_pkg::S_CHECK: begin
        unique case (func_q)
          spq_pkg::FUNC_POP: state_d = spq_pkg::S_DONE;
          spq_pkg::FUNC_FIND: begin
            state_d = stat_i.id_match ? spq_pkg::S_DONE : spq_pkg::S_READ;
          end
          default: begin
            if (stat_i.key_gt) begin
              shifting_d = 1'b1;
            end
            state_d = spq_pkg::S_READ;
          end
        endcase
      end
      spq_pkg::S_TAIL: state_d = spq_pkg::S_DONE;
      spq_pkg::S_DONE: begin
        if (stat_i.out_free) begin
          state_d = spq_pkg::S_IDLE;
        end
      end
      default: state_d = spq_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o        = '0;
    cmd_o.status = status_q;
    req_ready_o  = 1'b0;
    unique case (state_q)
      spq_pkg::S_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.start   = accept;
        cmd_o.clr_res = accept;
      end
      spq_pkg::S_READ: begin
        cmd_o.rd_req = !stat_i.idx_end;
      end
      spq_pkg::S_CHECK: begin
        unique case (func_q)
          spq_pkg::FUNC_POP: begin
            cmd_o.capture = 1'b1;
            cmd_o.pop     = 1'b1;
          end
          spq_pkg::FUNC_FIND: begin
            cmd_o.capture = stat_i.id_match;
            cmd_o.idx_inc = !stat_i.id_match;
          end
          default: begin
            cmd_o.shift_wr = shifting_q || stat_i.key_gt;
            cmd_o.idx_inc  = 1'b1;
          end
        endcase
      end
      spq_pkg::S_TAIL: begin
        cmd_o.tail_wr = 1'b1;
      end
      spq_pkg::S_DONE: begin
        cmd_o.load_out = stat_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// File: src/spq_dp.sv
module spq_dp #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [spq_pkg::KEY_W-1:0]    req_key_i,
  input  logic [spq_pkg::ID_W-1:0]     req_id_i,
  input  spq_pkg::cmd_t                cmd_i,
  output spq_pkg::stat_t               stat_o,
  input  logic                         rsp_ready_i,
  output logic                         rsp_valid_o,
  output logic [spq_pkg::STATUS_W-1:0] rsp_status_o,
  output logic [spq_pkg::KEY_W-1:0]    rsp_key_o,
  output logic [spq_pkg::ID_W-1:0]     rsp_id_o,
  output logic [spq_pkg::OCC_W-1:0]    rsp_occ_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  logic [spq_pkg::KEY_W-1:0] mem_key [DEPTH];
  logic [spq_pkg::ID_W-1:0]  mem_id  [DEPTH];

  logic [AW-1:0]             head_q, head_d;
  logic [CW-1:0]             count_q, count_d;
  logic [CW-1:0]             idx_q, idx_d;
  logic [spq_pkg::KEY_W-1:0] key_q, carry_key_q;
  logic [spq_pkg::ID_W-1:0]  id_q, carry_id_q;
  logic [spq_pkg::KEY_W-1:0] rd_key_q, res_key_q;
  logic [spq_pkg::ID_W-1:0]  rd_id_q, res_id_q;
  logic                      out_valid_q;

  logic [SW-1:0]             idx_sum, tail_sum;
  logic [AW-1:0]             idx_addr, tail_addr, wr_addr;
  logic                      wr_en;

  function automatic logic [AW-1:0] wrap_addr(input logic [SW-1:0] sum);
    logic [SW-1:0] fixed;
    fixed = (sum >= SW'(DEPTH)) ? (sum - SW'(DEPTH)) : sum;
    return fixed[AW-1:0];
  endfunction

  assign idx_sum   = SW'(head_q) + SW'(idx_q);
  assign tail_sum  = SW'(head_q) + SW'(count_q);
  assign idx_addr  = wrap_addr(idx_sum);
  assign tail_addr = wrap_addr(tail_sum);
  assign wr_en     = cmd_i.shift_wr || cmd_i.tail_wr;
  assign wr_addr   = cmd_i.tail_wr ? tail_addr : idx_addr;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_key[wr_addr] <= carry_key_q;
      mem_id[wr_addr]  <= carry_id_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_req) begin
      rd_key_q <= mem_key[idx_addr];
      rd_id_q  <= mem_id[idx_addr];
    end
  end

  assign stat_o.empty    = (count_q == '0);
  assign stat_o.full     = (count_q == CW'(DEPTH));
  assign stat_o.idx_end  = (idx_q == count_q);
  assign stat_o.key_gt   = (rd_key_q > key_q);
  assign stat_o.id_match = (rd_id_q == id_q);
  assign stat_o.out_free = !out_valid_q || rsp_ready_i;

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    idx_d   = idx_q;
    if (cmd_i.start) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + 1'b1;
    end
    if (cmd_i.pop) begin
      head_d  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end else if (cmd_i.tail_wr) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q       <= req_key_i;
      id_q        <= req_id_i;
      carry_key_q <= req_key_i;
      carry_id_q  <= req_id_i;
    end else if (cmd_i.shift_wr) begin
      carry_key_q <= rd_key_q;
      carry_id_q  <= rd_id_q;
    end
    if (cmd_i.clr_res) begin
      res_key_q <= '0;
      res_id_q  <= '0;
    end else if (cmd_i.capture) begin
      res_key_q <= rd_key_q;
      res_id_q  <= rd_id_q;
    end
    if (cmd_i.load_out) begin
      rsp_status_o <= cmd_i.status;
      rsp_key_o    <= res_key_q;
      rsp_id_o     <= res_id_q;
      rsp_occ_o    <= spq_pkg::OCC_W'(count_q);
    end
  end

  assign rsp_valid_o = out_valid_q;

endmodule

// File: src/sorted_process_queue.sv
// each request steps through the controller states: append writes at the tail,
// pop reads and checks the head entry, insert and find walk the entries held
// throughput: one request at a time; each entry visited costs a memory read and
// a compare on the single read port of the entry memory
// a new request is taken as soon as the result is in the output register
// reset: asynchronous, active low; clears the queue to empty, no clearing pass
module sorted_process_queue #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spq_req_if.sink    req_i,
  spq_rsp_if.source  rsp_o
);

  spq_pkg::cmd_t  cmd;
  spq_pkg::stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_func_i  (req_i.func),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  spq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_key_i    (req_i.entry_key),
    .req_id_i     (req_i.entry_id),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_status_o (rsp_o.status),
    .rsp_key_o    (rsp_o.out_key),
    .rsp_id_o     (rsp_o.out_id),
    .rsp_occ_o    (rsp_o.occupancy)
  );

endmodule

// File: test/tb_sorted_process_queue.sv
`timescale 1ns / 1ps

module tb_sorted_process_queue;
  import spq_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned RANDOM_ITEMS = 1200;

  typedef struct {
    func_e           op;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  pid;
    bit              hold;
  } request_t;

  typedef struct {
    status_e          status;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  pid;
    logic [OCC_W-1:0] occupancy;
  } queue_result_t;

  logic clk;
  logic rst_n;

  spq_req_if req_if ();
  spq_rsp_if rsp_if ();

  sorted_process_queue #(
    .DEPTH(DEPTH_DEF)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  request_t      pending_requests[$];
  queue_result_t expected_results[$];

  logic [KEY_W-1:0] model_keys[DEPTH_DEF];
  logic [ID_W-1:0]  model_ids[DEPTH_DEF];
  int               model_fill;

  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned results_checked;
  int unsigned full_drops;
  int unsigned empty_pops;
  int unsigned find_hits;
  int unsigned find_misses;
  int unsigned idle_cycles;
  logic        req_fire;

  int unsigned gap_left;
  int unsigned burst_left;
  int unsigned mode_left;
  int unsigned stall_mode;
  logic [7:0]  stall_pattern;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // queue after one operation, and the result it gives
  function automatic queue_result_t run_queue_op(func_e op, logic [KEY_W-1:0] key,
                                                 logic [ID_W-1:0] pid);
    queue_result_t r;
    int            pos;
    int            i;
    bit            found;
    r = '{status: ST_OK, key: '0, pid: '0, occupancy: '0};
    found = 1'b0;
    case (op)
      FUNC_APPEND, FUNC_INSERT: begin
        if (model_fill >= DEPTH_DEF) begin
          r.status = ST_FULL;
          full_drops++;
        end else begin
          pos = model_fill;
          if (op == FUNC_INSERT) begin
            for (i = model_fill - 1; i >= 0; i--) begin
              if (model_keys[i] > key) pos = i;
            end
          end
          for (i = model_fill; i > pos; i--) begin
            model_keys[i] = model_keys[i-1];
            model_ids[i]  = model_ids[i-1];
          end
          model_keys[pos] = key;
          model_ids[pos]  = pid;
          model_fill++;
        end
      end
      FUNC_POP: begin
        if (model_fill == 0) begin
          r.status = ST_EMPTY;
          empty_pops++;
        end else begin
          r.key = model_keys[0];
          r.pid = model_ids[0];
          for (i = 1; i < model_fill; i++) begin
            model_keys[i-1] = model_keys[i];
            model_ids[i-1]  = model_ids[i];
          end
          model_fill--;
        end
      end
      default: begin
        for (i = 0; i < model_fill; i++) begin
          if (!found && model_ids[i] == pid) begin
            found = 1'b1;
            r.key = model_keys[i];
            r.pid = model_ids[i];
          end
        end
        if (found) begin
          find_hits++;
        end else begin
          r.status = ST_NOTFOUND;
          find_misses++;
        end
      end
    endcase
    r.occupancy = model_fill[OCC_W-1:0];
    return r;
  endfunction

  function automatic void add_request(func_e op, logic [KEY_W-1:0] key,
                                      logic [ID_W-1:0] pid, bit hold);
    request_t req;
    req = '{op: op, key: key, pid: pid, hold: hold};
    pending_requests.push_back(req);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return KEY_W'($urandom_range(0, 7));
    if (sel < 60) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return KEY_W'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 1) != 0) return ID_W'($urandom_range(0, 15));
    return ID_W'($urandom_range(0, 16'hFFFF));
  endfunction

  // fill, drain and mixed phases so the queue swings between full and empty
  function automatic func_e pick_op(int unsigned phase);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    case (phase)
      0: begin
        if (sel < 45) return FUNC_INSERT;
        if (sel < 80) return FUNC_APPEND;
        if (sel < 90) return FUNC_POP;
        return FUNC_FIND;
      end
      1: begin
        if (sel < 60) return FUNC_POP;
        if (sel < 80) return FUNC_FIND;
        if (sel < 90) return FUNC_INSERT;
        return FUNC_APPEND;
      end
      default: return func_e'(sel % 4);
    endcase
  endfunction

  // stimulus, end of run and verdict
  initial begin
    int unsigned n;
    int unsigned phase;
    int unsigned phase_left;
    int          i;
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.func = FUNC_APPEND;
    req_if.entry_key = '0;
    req_if.entry_id = '0;
    rsp_if.ready = 1'b0;
    model_fill = 0;

    add_request(FUNC_POP, 16'h1234, 16'h4321, 1'b0);
    add_request(FUNC_FIND, 16'h0000, 16'h0000, 1'b0);
    add_request(FUNC_APPEND, 16'h0000, 16'h0000, 1'b0);
    add_request(FUNC_APPEND, 16'hFFFF, 16'hFFFF, 1'b0);
    add_request(FUNC_INSERT, 16'h8000, 16'h1234, 1'b0);
    add_request(FUNC_INSERT, 16'h8000, 16'h5555, 1'b0);
    add_request(FUNC_INSERT, 16'h0000, 16'hAAAA, 1'b0);
    add_request(FUNC_INSERT, 16'hFFFF, 16'h0001, 1'b0);
    add_request(FUNC_FIND, 16'hFFFF, 16'hFFFF, 1'b0);
    add_request(FUNC_FIND, 16'h0000, 16'h1234, 1'b0);
    add_request(FUNC_FIND, 16'h0000, 16'h7777, 1'b0);
    add_request(FUNC_POP, 16'h0000, 16'h0000, 1'b0);
    for (i = 0; i < 11; i++) begin
      add_request(FUNC_INSERT, KEY_W'(16'h7FFF + (i % 3)), ID_W'(16'h0100 + i), 1'b0);
    end
    add_request(FUNC_APPEND, 16'h5A5A, 16'hA5A5, 1'b0);
    add_request(FUNC_INSERT, 16'h0000, 16'h0000, 1'b0);

    phase = 0;
    phase_left = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase = $urandom_range(0, 2);
        phase_left = $urandom_range(10, 60);
      end
      phase_left--;
      add_request(pick_op(phase), pick_key(), pick_id(), (n % 150) == 0);
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || req_if.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);

    $display("%0d requests driven, %0d results checked", requests_sent, results_checked);
    $display("full drops %0d, empty pops %0d, finds hit %0d, finds missed %0d",
             full_drops, empty_pops, find_hits, find_misses);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // request driver: bursts with gaps, some requests wait until all earlier results are checked
  always @(negedge clk) begin
    request_t req;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else if (!req_if.valid || req_fire) begin
      if (gap_left != 0) begin
        gap_left--;
        req_if.valid <= 1'b0;
      end else if (pending_requests.size() != 0 &&
                   (!pending_requests[0].hold || expected_results.size() == 0)) begin
        req = pending_requests.pop_front();
        req_if.valid <= 1'b1;
        req_if.func <= req.op;
        req_if.entry_key <= req.key;
        req_if.entry_id <= req.pid;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // result stall pattern
  always @(negedge clk) begin
    logic rdy;
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
      mode_left = 0;
      stall_mode = 0;
      stall_pattern = 8'hFF;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 120);
        stall_mode = $urandom_range(0, 2);
        stall_pattern = 8'($urandom_range(1, 255));
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 1) != 0);
        default: begin
          rdy = stall_pattern[0];
          stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
        end
      endcase
      rsp_if.ready <= rdy;
    end
  end

  // monitor: check results, then predict for a newly accepted request
  always @(posedge clk) begin
    queue_result_t exp_res;
    if (!rst_n) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= req_if.valid && req_if.ready;
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d key %h id %h occupancy %0d",
                 rsp_if.status, rsp_if.out_key, rsp_if.out_id, rsp_if.occupancy);
          mismatches++;
        end else begin
          exp_res = expected_results.pop_front();
          results_checked++;
          if (rsp_if.status !== exp_res.status) begin
            $error("status: expected %0d, actual %0d", exp_res.status, rsp_if.status);
            mismatches++;
          end
          if (rsp_if.out_key !== exp_res.key) begin
            $error("out_key: expected %h, actual %h", exp_res.key, rsp_if.out_key);
            mismatches++;
          end
          if (rsp_if.out_id !== exp_res.pid) begin
            $error("out_id: expected %h, actual %h", exp_res.pid, rsp_if.out_id);
            mismatches++;
          end
          if (rsp_if.occupancy !== exp_res.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", exp_res.occupancy,
                   rsp_if.occupancy);
            mismatches++;
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        requests_sent++;
        expected_results.push_back(run_queue_op(func_e'(req_if.func), req_if.entry_key,
                                                req_if.entry_id));
      end
    end
  end

  // watchdog on cycles with work outstanding but no handshake
  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (pending_requests.size() == 0 && !req_if.valid && expected_results.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no request or result accepted for %0d cycles", IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: filelist.f
src/spq_pkg.sv
src/spq_req_if.sv
src/spq_rsp_if.sv
src/spq_ctrl.sv
src/spq_dp.sv
src/sorted_process_queue.sv
test/tb_sorted_process_queue.sv
